[hdl/kf2d_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package kf2d_pkg;

    localparam int DATA_W    = 48;
    localparam int ADDR_W    = 8;
    localparam int RAM_DEPTH = 256;

    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic signed [DATA_W-1:0] fx_t;

    // Scratch memory map.
    localparam addr_t A_X    = 8'd0;
    localparam addr_t A_XP   = 8'd8;
    localparam addr_t A_K    = 8'd16;
    localparam addr_t A_Y    = 8'd28;
    localparam addr_t A_Z    = 8'd32;
    localparam addr_t A_DT   = 8'd34;
    localparam addr_t A_QN   = 8'd35;
    localparam addr_t A_RN   = 8'd36;
    localparam addr_t A_S0   = 8'd37;
    localparam addr_t A_S1   = 8'd38;
    localparam addr_t A_T    = 8'd39;
    localparam addr_t A_DET  = 8'd40;
    localparam addr_t A_ZERO = 8'd41;
    localparam addr_t A_P    = 8'd48;
    localparam addr_t A_AP   = 8'd88;
    localparam addr_t A_PP   = 8'd128;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_SAT  = 2'd1;
    localparam logic [1:0] STATUS_SING = 2'd2;

    localparam logic [1:0] CFG_TIME_STEP     = 2'd0;
    localparam logic [1:0] CFG_PROCESS_NOISE = 2'd1;
    localparam logic [1:0] CFG_MEAS_NOISE    = 2'd2;

    typedef enum logic [3:0] {
        PH_XP, PH_AP, PH_PP, PH_PQ, PH_S, PH_DET, PH_K, PH_Y, PH_X, PH_P
    } phase_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_LOAD, ST_RA, ST_RB, ST_RC, ST_RD, ST_START,
        ST_WAIT, ST_WB, ST_RX0, ST_RX1, ST_RX2, ST_EMIT
    } exec_state_t;

    // One operation: dst = a +/- (has_mul ? b*c : b), or dst = a / b.
    typedef struct packed {
        addr_t dst;
        addr_t a;
        addr_t b;
        addr_t c;
        logic  has_mul;
        logic  sub;
        logic  is_div;
        logic  last;
    } uop_t;

    typedef struct packed {
        logic sat;
        fx_t  val;
    } sat_val_t;

    function automatic logic [DATA_W-1:0] mag(input fx_t v);
        logic [DATA_W-1:0] r;
        r = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
        return r;
    endfunction

    function automatic sat_val_t add_sat(input fx_t a, input fx_t b, input logic sub);
        logic signed [DATA_W:0] s;
        sat_val_t               r;
        if (sub)
            s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        else
            s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        r.sat = (s[DATA_W] != s[DATA_W-1]);
        if (r.sat)
            r.val = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        else
            r.val = s[DATA_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/kf2d_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module kf2d_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

[hdl/kf2d_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

module kf2d_mul import kf2d_pkg::*; #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire fx_t  a,
    input  wire fx_t  b,
    output logic      done,
    output fx_t       result,
    output logic      sat
);

    localparam int HALF   = DATA_W / 2;
    localparam int PROD_W = 2 * DATA_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic [2:0] CNT_ROUND = 3'd5;

    logic [DATA_W-1:0] ma_reg, mb_reg;
    logic              neg_reg;
    logic [2*HALF-1:0] prod_reg;
    logic [1:0]        part_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [2:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    fx_t               result_reg;
    logic              sat_reg;

    logic [HALF-1:0]   a_sel, b_sel;
    logic [PROD_W-1:0] addend;
    logic [SUM_W-1:0]  sum, quo, lim;
    logic [DATA_W-1:0] m;
    logic              ovf;

    always_comb
    begin
        a_sel = cnt_reg[1] ? ma_reg[DATA_W-1:HALF] : ma_reg[HALF-1:0];
        b_sel = cnt_reg[0] ? mb_reg[DATA_W-1:HALF] : mb_reg[HALF-1:0];
        case (part_reg)
            2'd0:    addend = PROD_W'(prod_reg);
            2'd3:    addend = PROD_W'(prod_reg) << (2 * HALF);
            default: addend = PROD_W'(prod_reg) << HALF;
        endcase
        // Round half away from zero on the magnitude, then clamp.
        sum = {1'b0, acc_reg} + RND;
        quo = sum >> FRAC_BITS;
        lim = neg_reg ? SUM_W'({1'b1, {(DATA_W-1){1'b0}}})
                      : SUM_W'({1'b0, {(DATA_W-1){1'b1}}});
        ovf = (quo > lim);
        m   = ovf ? lim[DATA_W-1:0] : quo[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_ROUND)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= mag(a);
            mb_reg  <= mag(b);
            neg_reg <= a[DATA_W-1] ^ b[DATA_W-1];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg < 3'd4)
            begin
                prod_reg <= a_sel * b_sel;
                part_reg <= cnt_reg[1:0];
            end
            if (cnt_reg != 3'd0 && cnt_reg < CNT_ROUND)
            begin
                acc_reg <= acc_reg + addend;
            end
            if (cnt_reg == CNT_ROUND)
            begin
                result_reg <= neg_reg ? fx_t'(-m) : fx_t'(m);
                sat_reg    <= ovf;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;
    assign sat    = sat_reg;

endmodule

`default_nettype wire

[hdl/kf2d_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module kf2d_div import kf2d_pkg::*; #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire fx_t  num,
    input  wire fx_t  den,
    output logic      done,
    output fx_t       result,
    output logic      sat
);

    localparam int QW    = DATA_W + FRAC_BITS;
    localparam int CNT_W = $clog2(QW + 1);

    logic [QW-1:0]     dv_reg, q_reg;
    logic [DATA_W-1:0] rem_reg, d_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              neg_reg;
    logic              busy_reg;
    logic              done_reg;
    fx_t               result_reg;
    logic              sat_reg;

    logic [DATA_W:0]   trial;
    logic              fits;
    logic [QW-1:0]     lim;
    logic              ovf;
    logic [DATA_W-1:0] m;

    always_comb
    begin
        trial = {rem_reg, dv_reg[QW-1]};
        fits  = (trial >= {1'b0, d_reg});
        lim   = neg_reg ? QW'({1'b1, {(DATA_W-1){1'b0}}})
                        : QW'({1'b0, {(DATA_W-1){1'b1}}});
        ovf   = (q_reg > lim);
        m     = ovf ? lim[DATA_W-1:0] : q_reg[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                // A zero divisor returns zero at once.
                busy_reg <= (mag(den) != '0);
                done_reg <= (mag(den) == '0);
                cnt_reg  <= CNT_W'(QW);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dv_reg     <= {mag(num), {FRAC_BITS{1'b0}}};
            d_reg      <= mag(den);
            q_reg      <= '0;
            rem_reg    <= '0;
            neg_reg    <= num[DATA_W-1] ^ den[DATA_W-1];
            result_reg <= '0;
            sat_reg    <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                rem_reg <= fits ? DATA_W'(trial - {1'b0, d_reg}) : trial[DATA_W-1:0];
                q_reg   <= {q_reg[QW-2:0], fits};
                dv_reg  <= {dv_reg[QW-2:0], 1'b0};
            end
            else
            begin
                result_reg <= neg_reg ? fx_t'(-m) : fx_t'(m);
                sat_reg    <= ovf;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;
    assign sat    = sat_reg;

endmodule

`default_nettype wire

[hdl/kf2d_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

module kf2d_seq import kf2d_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic advance,
    output uop_t      uop
);

    phase_t     phase_reg, phase_next;
    logic [2:0] i_reg, j_reg, s_reg;
    logic [2:0] i_next, j_next, s_next;
    logic [2:0] i_max, j_max, s_max;
    addr_t      m, i_a, i2;

    function automatic addr_t idx6(input logic [2:0] i, input logic [2:0] j);
        return addr_t'({i, 2'b00}) + addr_t'({i, 1'b0}) + addr_t'(j);
    endfunction

    always_comb
    begin
        case (phase_reg)
            PH_XP:   begin i_max = 3'd5; j_max = 3'd0; s_max = 3'd0; end
            PH_AP:   begin i_max = 3'd5; j_max = 3'd5; s_max = 3'd0; end
            PH_PP:   begin i_max = 3'd5; j_max = 3'd5; s_max = 3'd0; end
            PH_PQ:   begin i_max = 3'd5; j_max = 3'd0; s_max = 3'd0; end
            PH_S:    begin i_max = 3'd1; j_max = 3'd0; s_max = 3'd0; end
            PH_DET:  begin i_max = 3'd0; j_max = 3'd0; s_max = 3'd1; end
            PH_K:    begin i_max = 3'd5; j_max = 3'd0; s_max = 3'd5; end
            PH_Y:    begin i_max = 3'd1; j_max = 3'd0; s_max = 3'd0; end
            PH_X:    begin i_max = 3'd5; j_max = 3'd0; s_max = 3'd1; end
            PH_P:    begin i_max = 3'd5; j_max = 3'd5; s_max = 3'd1; end
            default: begin i_max = 3'd0; j_max = 3'd0; s_max = 3'd0; end
        endcase
    end

    // Next state: step the innermost counter, then j, then i, then the phase.
    always_comb
    begin
        phase_next = phase_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        s_next     = s_reg;
        if (advance)
        begin
            if (s_reg != s_max)
            begin
                s_next = s_reg + 3'd1;
            end
            else
            begin
                s_next = '0;
                if (j_reg != j_max)
                begin
                    j_next = j_reg + 3'd1;
                end
                else
                begin
                    j_next = '0;
                    if (i_reg != i_max)
                    begin
                        i_next = i_reg + 3'd1;
                    end
                    else
                    begin
                        i_next = '0;
                        case (phase_reg)
                            PH_XP:   phase_next = PH_AP;
                            PH_AP:   phase_next = PH_PP;
                            PH_PP:   phase_next = PH_PQ;
                            PH_PQ:   phase_next = PH_S;
                            PH_S:    phase_next = PH_DET;
                            PH_DET:  phase_next = PH_K;
                            PH_K:    phase_next = PH_Y;
                            PH_Y:    phase_next = PH_X;
                            PH_X:    phase_next = PH_P;
                            default: phase_next = PH_XP;
                        endcase
                    end
                end
            end
        end
    end

    // Outputs: the operation for the current counters.
    always_comb
    begin
        m   = idx6(i_reg, j_reg);
        i_a = addr_t'(i_reg);
        i2  = addr_t'({i_reg, 1'b0});
        uop.dst     = A_T;
        uop.a       = A_ZERO;
        uop.b       = A_ZERO;
        uop.c       = A_ZERO;
        uop.has_mul = 1'b0;
        uop.sub     = 1'b0;
        uop.is_div  = 1'b0;
        uop.last    = (phase_reg == PH_P) && (i_reg == i_max) && (j_reg == j_max)
                      && (s_reg == s_max);
        case (phase_reg)
            PH_XP:
            begin
                uop.dst = A_XP + i_a;
                uop.a   = A_X + i_a;
                if (i_reg < 3'd4)
                begin
                    uop.has_mul = 1'b1;
                    uop.b       = A_DT;
                    uop.c       = A_X + i_a + addr_t'(2);
                end
            end
            PH_AP:
            begin
                uop.dst = A_AP + m;
                uop.a   = A_P + m;
                if (i_reg < 3'd4)
                begin
                    uop.has_mul = 1'b1;
                    uop.b       = A_DT;
                    uop.c       = A_P + m + addr_t'(12);
                end
            end
            PH_PP:
            begin
                uop.dst = A_PP + m;
                uop.a   = A_AP + m;
                if (j_reg < 3'd4)
                begin
                    uop.has_mul = 1'b1;
                    uop.b       = A_AP + m + addr_t'(2);
                    uop.c       = A_DT;
                end
            end
            PH_PQ:
            begin
                uop.dst = A_PP + idx6(i_reg, i_reg);
                uop.a   = A_PP + idx6(i_reg, i_reg);
                uop.b   = A_QN;
            end
            PH_S:
            begin
                uop.dst = i_reg[0] ? A_S1 : A_S0;
                uop.a   = A_PP + (i_reg[0] ? addr_t'(7) : addr_t'(0));
                uop.b   = A_RN;
            end
            PH_DET:
            begin
                uop.has_mul = 1'b1;
                if (s_reg[0])
                begin
                    uop.dst = A_DET;
                    uop.a   = A_T;
                    uop.b   = A_PP + addr_t'(6);
                    uop.c   = A_PP + addr_t'(1);
                    uop.sub = 1'b1;
                end
                else
                begin
                    uop.b = A_S0;
                    uop.c = A_S1;
                end
            end
            PH_K:
            begin
                case (s_reg)
                    3'd0:
                    begin
                        uop.has_mul = 1'b1;
                        uop.b       = A_S1;
                        uop.c       = A_PP + idx6(i_reg, 3'd0);
                    end
                    3'd1:
                    begin
                        uop.has_mul = 1'b1;
                        uop.sub     = 1'b1;
                        uop.a       = A_T;
                        uop.b       = A_PP + addr_t'(6);
                        uop.c       = A_PP + idx6(i_reg, 3'd1);
                    end
                    3'd2:
                    begin
                        uop.is_div = 1'b1;
                        uop.dst    = A_K + i2;
                        uop.a      = A_T;
                        uop.b      = A_DET;
                    end
                    3'd3:
                    begin
                        uop.has_mul = 1'b1;
                        uop.b       = A_S0;
                        uop.c       = A_PP + idx6(i_reg, 3'd1);
                    end
                    3'd4:
                    begin
                        uop.has_mul = 1'b1;
                        uop.sub     = 1'b1;
                        uop.a       = A_T;
                        uop.b       = A_PP + addr_t'(1);
                        uop.c       = A_PP + idx6(i_reg, 3'd0);
                    end
                    default:
                    begin
                        uop.is_div = 1'b1;
                        uop.dst    = A_K + i2 + addr_t'(1);
                        uop.a      = A_T;
                        uop.b      = A_DET;
                    end
                endcase
            end
            PH_Y:
            begin
                uop.dst = A_Y + i_a;
                uop.a   = A_Z + i_a;
                uop.b   = A_XP + i_a;
                uop.sub = 1'b1;
            end
            PH_X:
            begin
                uop.has_mul = 1'b1;
                uop.dst     = A_X + i_a;
                uop.a       = s_reg[0] ? (A_X + i_a) : (A_XP + i_a);
                uop.b       = A_K + i2 + addr_t'(s_reg[0]);
                uop.c       = A_Y + addr_t'(s_reg[0]);
            end
            default:
            begin
                uop.has_mul = 1'b1;
                uop.sub     = 1'b1;
                uop.dst     = A_P + m;
                uop.a       = s_reg[0] ? (A_P + m) : (A_PP + m);
                uop.b       = A_K + i2 + addr_t'(s_reg[0]);
                uop.c       = A_PP + addr_t'(j_reg) + (s_reg[0] ? addr_t'(6) : addr_t'(0));
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_XP;
            i_reg     <= '0;
            j_reg     <= '0;
            s_reg     <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            s_reg     <= s_next;
        end
    end

endmodule

`default_nettype wire

[hdl/kalman_filter_const_accel_2d_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Two-dimensional constant-acceleration Kalman tracker.
// Input channel (in_valid/in_ready) transfers one measured position meas_x,
// meas_y in signed Q16.16. Output channel (out_valid/out_ready) transfers the
// updated position est_x, est_y and numeric_status (ok, saturated, singular).
// Configuration channel (cfg_valid/cfg_ready, always ready) writes time_step,
// process_noise or meas_noise by cfg_index; write only while no item is open.
// Every step runs as one operation: a saturating add, or one on a shared
// multiplier or a shared restoring divider, operands coming from a 256-word
// scratch memory. One item runs 162 multiply operations, 36 add operations
// and 12 divides; the divider yields one quotient bit a cycle, and the
// multiplier sums four 24x24 partial products.
// in_ready is high only between items. A finished result waits in the
// output register; the next item is taken meanwhile, and only its own result
// stalls until out_ready has taken the earlier one.
// After reset the block clears every scratch memory word with in_ready low;
// configuration writes are taken during that time as ever.
module kalman_filter_const_accel_2d_top import kf2d_pkg::*; #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] meas_x,
    input  wire logic signed [31:0] meas_y,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      est_x,
    output logic signed [31:0]      est_y,
    output logic [1:0]              numeric_status,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [40:0]        cfg_data
);

    localparam int CONV_SH = FRAC_BITS - 16;
    localparam logic [DATA_W:0] CONV_RND = ((DATA_W+1)'(1) << CONV_SH) >> 1;
    localparam logic [DATA_W:0] PORT_POS = (DATA_W+1)'(33'h07FFFFFFF);
    localparam logic [DATA_W:0] PORT_NEG = (DATA_W+1)'(33'h080000000);
    localparam logic [32:0] DT_RESET = 33'(1) << FRAC_BITS;
    localparam logic [40:0] QN_RESET = 41'(1) << FRAC_BITS;
    localparam logic [40:0] RN_RESET = 41'(1000) << FRAC_BITS;
    localparam logic [2:0] LD_Z0 = 3'd0;
    localparam logic [2:0] LD_Z1 = 3'd1;
    localparam logic [2:0] LD_DT = 3'd2;
    localparam logic [2:0] LD_QN = 3'd3;
    localparam logic [2:0] LD_RN = 3'd4;

    exec_state_t state_reg, state_next;
    addr_t       clr_reg;
    logic [2:0]  ld_reg;
    logic signed [31:0] mx_reg, my_reg;
    logic [32:0] dt_reg;
    logic [40:0] qn_reg, rn_reg;
    fx_t         opa_reg, opb_reg, opc_reg, res_reg;
    logic        sat_reg, sing_reg;
    logic signed [31:0] ex_reg, ey_reg;
    logic        out_valid_reg;
    logic signed [31:0] est_x_reg, est_y_reg;
    logic [1:0]  status_reg;

    logic        we;
    addr_t       waddr, raddr;
    fx_t         wdata, rdata;
    logic        advance, mul_start, div_start;
    uop_t        uop;
    logic        mul_done, mul_sat, div_done, div_sat;
    fx_t         mul_res, div_res;
    fx_t         load_data;
    sat_val_t    plain_sum, mul_sum;
    logic        emit_ok;

    logic              cv_neg, cv_sat;
    logic [DATA_W-1:0] cv_mag;
    logic [DATA_W:0]   cv_q, cv_m;
    logic signed [31:0] cv_val;

    kf2d_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    kf2d_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .uop     (uop)
    );

    kf2d_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (opb_reg),
        .b      (opc_reg),
        .done   (mul_done),
        .result (mul_res),
        .sat    (mul_sat)
    );

    kf2d_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (opa_reg),
        .den    (opb_reg),
        .done   (div_done),
        .result (div_res),
        .sat    (div_sat)
    );

    always_comb
    begin
        plain_sum = add_sat(opa_reg, opb_reg, uop.sub);
        mul_sum   = add_sat(opa_reg, mul_res, uop.sub);
        emit_ok   = !out_valid_reg || out_ready;
        case (ld_reg)
            LD_Z0:   load_data = fx_t'(mx_reg) <<< CONV_SH;
            LD_Z1:   load_data = fx_t'(my_reg) <<< CONV_SH;
            LD_DT:   load_data = fx_t'(dt_reg);
            LD_QN:   load_data = fx_t'(qn_reg);
            default: load_data = fx_t'(rn_reg);
        endcase
        // Port conversion of the word on the read port.
        cv_neg = rdata[DATA_W-1];
        cv_mag = mag(rdata);
        cv_q   = ({1'b0, cv_mag} + CONV_RND) >> CONV_SH;
        cv_sat = cv_neg ? (cv_q > PORT_NEG) : (cv_q > PORT_POS);
        cv_m   = cv_sat ? (cv_neg ? PORT_NEG : PORT_POS) : cv_q;
        cv_val = cv_neg ? -cv_m[31:0] : cv_m[31:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == '1) state_next = ST_IDLE;
            ST_IDLE:  if (in_valid) state_next = ST_LOAD;
            ST_LOAD:  if (ld_reg == LD_RN) state_next = ST_RA;
            ST_RA:    state_next = ST_RB;
            ST_RB:    state_next = ST_RC;
            ST_RC:    state_next = ST_RD;
            ST_RD:    state_next = ST_START;
            ST_START: state_next = (uop.is_div || uop.has_mul) ? ST_WAIT : ST_WB;
            ST_WAIT:
            begin
                if (uop.is_div ? div_done : mul_done)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:    state_next = uop.last ? ST_RX0 : ST_RA;
            ST_RX0:   state_next = ST_RX1;
            ST_RX1:   state_next = ST_RX2;
            ST_RX2:   state_next = ST_EMIT;
            ST_EMIT:  if (emit_ok) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        we        = 1'b0;
        waddr     = uop.dst;
        wdata     = res_reg;
        raddr     = A_ZERO;
        advance   = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        in_ready  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = '0;
            end
            ST_IDLE:  in_ready = 1'b1;
            ST_LOAD:
            begin
                we    = 1'b1;
                waddr = A_Z + addr_t'(ld_reg);
                wdata = load_data;
            end
            ST_RA:    raddr = uop.a;
            ST_RB:    raddr = uop.b;
            ST_RC:    raddr = uop.c;
            ST_START:
            begin
                mul_start = uop.has_mul && !uop.is_div;
                div_start = uop.is_div;
            end
            ST_WB:
            begin
                we      = 1'b1;
                advance = 1'b1;
            end
            ST_RX0:   raddr = A_X;
            ST_RX1:   raddr = A_X + addr_t'(1);
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            ld_reg        <= '0;
            dt_reg        <= DT_RESET;
            qn_reg        <= QN_RESET;
            rn_reg        <= RN_RESET;
            sat_reg       <= 1'b0;
            sing_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + addr_t'(1);
            end
            if (state_reg == ST_LOAD)
            begin
                ld_reg <= ld_reg + 3'd1;
            end
            if (state_reg == ST_IDLE && in_valid)
            begin
                ld_reg   <= LD_Z0;
                sat_reg  <= 1'b0;
                sing_reg <= 1'b0;
            end
            if (state_reg == ST_START && !uop.is_div && !uop.has_mul && plain_sum.sat)
            begin
                sat_reg <= 1'b1;
            end
            if (state_reg == ST_WAIT)
            begin
                if (uop.is_div && div_done && div_sat)
                begin
                    sat_reg <= 1'b1;
                end
                if (!uop.is_div && mul_done && (mul_sat || mul_sum.sat))
                begin
                    sat_reg <= 1'b1;
                end
            end
            if (state_reg == ST_WB && uop.dst == A_DET)
            begin
                sing_reg <= (res_reg == '0);
            end
            if ((state_reg == ST_RX1 || state_reg == ST_RX2) && cv_sat)
            begin
                sat_reg <= 1'b1;
            end
            if (state_reg == ST_EMIT && emit_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_TIME_STEP:     dt_reg <= cfg_data[32:0];
                    CFG_PROCESS_NOISE: qn_reg <= cfg_data;
                    CFG_MEAS_NOISE:    rn_reg <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            mx_reg <= meas_x;
            my_reg <= meas_y;
        end
        case (state_reg)
            ST_RB:    opa_reg <= rdata;
            ST_RC:    opb_reg <= rdata;
            ST_RD:    opc_reg <= rdata;
            ST_START: res_reg <= plain_sum.val;
            ST_WAIT:  res_reg <= uop.is_div ? div_res : mul_sum.val;
            ST_RX1:   ex_reg  <= cv_val;
            ST_RX2:   ey_reg  <= cv_val;
            default:  ;
        endcase
        if (state_reg == ST_EMIT && emit_ok)
        begin
            est_x_reg  <= ex_reg;
            est_y_reg  <= ey_reg;
            status_reg <= sing_reg ? STATUS_SING : (sat_reg ? STATUS_SAT : STATUS_OK);
        end
    end

    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign est_x          = est_x_reg;
    assign est_y          = est_y_reg;
    assign numeric_status = status_reg;

endmodule

`default_nettype wire

[hdl/kf2d_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module kf2d_chk import kf2d_pkg::*; (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [31:0] est_x,
    input wire logic signed [31:0] est_y,
    input wire logic [1:0]         numeric_status
);

    // An accepted item keeps the input side closed while it is worked on.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after a transfer");

    // No result can appear in the cycle right after an item is taken.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (numeric_status == STATUS_OK || numeric_status == STATUS_SAT
                       || numeric_status == STATUS_SING))
        else $error("undefined status code");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(est_x) && $stable(est_y)
                                    && $stable(numeric_status))
        else $error("stalled result changed");

endmodule

bind kalman_filter_const_accel_2d_top kf2d_chk u_chk (.*);

`default_nettype wire

[tb/sv/kf2d_tracker_checker.sv]
`timescale 1ns / 1ps

module kf2d_tracker_checker import kf2d_pkg::*; #(
    parameter int FRAC_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [31:0] meas_x,
    input  logic signed [31:0] meas_y,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] est_x,
    input  logic signed [31:0] est_y,
    input  logic [1:0]         numeric_status,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [40:0]        cfg_data,
    output int                 errors,
    output int                 pending
);

    localparam longint POS_LIM = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint NEG_LIM = -64'sh0000_8000_0000_0000;
    localparam longint PORT_SCALE = longint'(1) << (FRAC_BITS - 16);

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [1:0]  status;
    } estimate_t;

    estimate_t estimate_q[$];

    longint trk_state[6];
    longint trk_cov[36];
    longint time_step_r;
    longint proc_noise_r;
    longint meas_noise_r;
    bit     sat_seen;

    function automatic logic [63:0] magn(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint clamp48(longint v);
        if (v > POS_LIM) begin
            sat_seen = 1'b1;
            return POS_LIM;
        end
        if (v < NEG_LIM) begin
            sat_seen = 1'b1;
            return NEG_LIM;
        end
        return v;
    endfunction

    // Applies the sign to an unsigned magnitude, saturating at the 48-bit limits.
    function automatic longint signed_mag(logic [127:0] m, bit neg);
        if (neg && m > 128'h8000_0000_0000) begin
            sat_seen = 1'b1;
            return NEG_LIM;
        end
        if (!neg && m > 128'h7FFF_FFFF_FFFF) begin
            sat_seen = 1'b1;
            return POS_LIM;
        end
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        logic [127:0] prod;
        prod = 128'(magn(a)) * 128'(magn(b));
        prod = (prod + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return signed_mag(prod, (a < 0) != (b < 0));
    endfunction

    function automatic longint fx_div(longint n, longint d);
        logic [127:0] quo;
        if (d == 0)
            return 0;
        quo = (128'(magn(n)) << FRAC_BITS) / 128'(magn(d));
        return signed_mag(quo, (n < 0) != (d < 0));
    endfunction

    function automatic logic [31:0] to_q16(longint v);
        logic [63:0] m;
        m = (magn(v) + (64'd1 << (FRAC_BITS - 17))) >> (FRAC_BITS - 16);
        if (v >= 0 && m > 64'h7FFF_FFFF) begin
            sat_seen = 1'b1;
            m = 64'h7FFF_FFFF;
        end
        if (v < 0 && m > 64'h8000_0000) begin
            sat_seen = 1'b1;
            m = 64'h8000_0000;
        end
        return (v < 0) ? 32'(-m) : 32'(m);
    endfunction

    function automatic estimate_t track_update(logic signed [31:0] mx, logic signed [31:0] my);
        longint    xp[6];
        longint    ap[36];
        longint    pp[36];
        longint    gain[12];
        longint    z0, z1, s00, s01, s10, s11, det, y0, y1, b0, b1, v;
        bit        singular;
        estimate_t res;
        sat_seen = 1'b0;
        z0 = longint'(mx) * PORT_SCALE;
        z1 = longint'(my) * PORT_SCALE;
        for (int i = 0; i < 6; i++)
            xp[i] = (i < 4) ? clamp48(trk_state[i] + fx_mul(time_step_r, trk_state[i+2]))
                            : trk_state[i];
        for (int i = 0; i < 6; i++)
            for (int j = 0; j < 6; j++)
                ap[i*6+j] = (i < 4) ? clamp48(trk_cov[i*6+j]
                                              + fx_mul(time_step_r, trk_cov[(i+2)*6+j]))
                                    : trk_cov[i*6+j];
        for (int i = 0; i < 6; i++)
            for (int j = 0; j < 6; j++) begin
                v = ap[i*6+j];
                if (j < 4)
                    v = clamp48(v + fx_mul(ap[i*6+j+2], time_step_r));
                if (i == j)
                    v = clamp48(v + proc_noise_r);
                pp[i*6+j] = v;
            end
        s00 = clamp48(pp[0] + meas_noise_r);
        s01 = pp[6];
        s10 = pp[1];
        s11 = clamp48(pp[7] + meas_noise_r);
        det = clamp48(fx_mul(s00, s11) - fx_mul(s01, s10));
        singular = (det == 0);
        for (int i = 0; i < 6; i++) begin
            b0 = pp[i*6];
            b1 = pp[i*6+1];
            if (singular) begin
                gain[i*2]   = 0;
                gain[i*2+1] = 0;
            end else begin
                gain[i*2]   = fx_div(clamp48(fx_mul(s11, b0) - fx_mul(s01, b1)), det);
                gain[i*2+1] = fx_div(clamp48(fx_mul(s00, b1) - fx_mul(s10, b0)), det);
            end
        end
        y0 = clamp48(z0 - xp[0]);
        y1 = clamp48(z1 - xp[1]);
        for (int i = 0; i < 6; i++) begin
            v = clamp48(xp[i] + fx_mul(gain[i*2], y0));
            trk_state[i] = clamp48(v + fx_mul(gain[i*2+1], y1));
        end
        for (int i = 0; i < 6; i++)
            for (int j = 0; j < 6; j++) begin
                v = clamp48(pp[i*6+j] - fx_mul(gain[i*2], pp[j]));
                trk_cov[i*6+j] = clamp48(v - fx_mul(gain[i*2+1], pp[6+j]));
            end
        res.x = to_q16(trk_state[0]);
        res.y = to_q16(trk_state[1]);
        res.status = singular ? STATUS_SING : (sat_seen ? STATUS_SAT : STATUS_OK);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        estimate_t want;
        if (!rst_n) begin
            for (int i = 0; i < 6; i++)
                trk_state[i] = 0;
            for (int i = 0; i < 36; i++)
                trk_cov[i] = 0;
            time_step_r  = longint'(1) << FRAC_BITS;
            proc_noise_r = longint'(1) << FRAC_BITS;
            meas_noise_r = longint'(1000) << FRAC_BITS;
            estimate_q.delete();
            errors  = 0;
            pending = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TIME_STEP:     time_step_r  = longint'(cfg_data[32:0]);
                    CFG_PROCESS_NOISE: proc_noise_r = longint'(cfg_data);
                    CFG_MEAS_NOISE:    meas_noise_r = longint'(cfg_data);
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                estimate_q.push_back(track_update(meas_x, meas_y));
            if (out_valid && out_ready) begin
                if (estimate_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result transfer est_x %h est_y %h status %0d",
                             $time, est_x, est_y, numeric_status);
                end else begin
                    want = estimate_q.pop_front();
                    if (est_x !== want.x) begin
                        errors++;
                        $display("%0t: est_x expected %h actual %h", $time, want.x, est_x);
                    end
                    if (est_y !== want.y) begin
                        errors++;
                        $display("%0t: est_y expected %h actual %h", $time, want.y, est_y);
                    end
                    if (numeric_status !== want.status) begin
                        errors++;
                        $display("%0t: numeric_status expected %0d actual %0d",
                                 $time, want.status, numeric_status);
                    end
                end
            end
            pending = estimate_q.size();
        end
    end

endmodule

[tb/sv/tb_kalman_filter_const_accel_2d_top.sv]
`timescale 1ns / 1ps

module tb_kalman_filter_const_accel_2d_top;
    import kf2d_pkg::*;

    localparam logic [1:0]  CFG_UNUSED  = 2'd3;
    localparam longint      ONE         = longint'(1) << 24;
    localparam longint      DT_MAX      = longint'(1) << 32;
    localparam longint      NOISE_MAX   = longint'(1) << 40;
    localparam int          HOLD_CYCLES = 12000;
    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 125;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic [1:0]         numeric_status;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [40:0]        cfg_data;
    int                 errors;
    int                 pending;
    bit                 hold_req;

    kalman_filter_const_accel_2d_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .meas_x(meas_x), .meas_y(meas_y),
        .out_valid(out_valid), .out_ready(out_ready), .est_x(est_x), .est_y(est_y),
        .numeric_status(numeric_status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    kf2d_tracker_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .meas_x(meas_x), .meas_y(meas_y),
        .out_valid(out_valid), .out_ready(out_ready), .est_x(est_x), .est_y(est_y),
        .numeric_status(numeric_status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .errors(errors), .pending(pending)
    );

    always #10 clk = ~clk;

    initial begin
        #(500_000_000);
        $display("kalman_filter_const_accel_2d_top verification failed");
        $finish;
    end

    // Holds valid until the transfer; the caller lowers it only when a gap follows.
    task automatic send_meas(logic [31:0] x, logic [31:0] y);
        in_valid <= 1'b1;
        meas_x   <= x;
        meas_y   <= y;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic sender_gap();
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        gap  = (pick < 60) ? 0 : (pick < 95) ? $urandom_range(1, 5) : $urandom_range(50, 600);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, longint value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[40:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        @(posedge clk);
        wait (pending == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_regs(longint dt, longint q, longint r);
        write_reg(CFG_TIME_STEP, dt);
        write_reg(CFG_PROCESS_NOISE, q);
        write_reg(CFG_MEAS_NOISE, r);
    endtask

    initial begin
        int pick;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                pick = $urandom_range(0, 99);
                out_ready <= (pick < 55);
                if (pick < 55)
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                else if (pick < 93)
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                else
                    repeat ($urandom_range(100, 2000)) @(posedge clk);
            end
        end
    end

    initial begin
        longint dt, q, r;
        int     pick;
        int     px, py, vx, vy, ax, ay;
        clk       = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        meas_x    = '0;
        meas_y    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TIME_STEP;
        cfg_data  = '0;
        hold_req  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero noise on a zero covariance leaves the innovation covariance singular.
        write_reg(CFG_PROCESS_NOISE, 0);
        write_reg(CFG_MEAS_NOISE, 0);
        send_meas(32'h0000_0000, 32'h0000_0000);
        send_meas(32'h7FFF_FFFF, 32'h8000_0000);
        send_meas(32'h0000_0001, 32'hFFFF_FFFF);
        drain();

        // The time step DT_MAX, 2^32, with full-scale inputs drives saturation.
        set_regs(DT_MAX, ONE, ONE);
        send_meas(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_meas(32'h8000_0000, 32'h8000_0000);
        send_meas(32'h7FFF_FFFF, 32'h8000_0000);
        send_meas(32'h0000_0000, 32'h0000_0000);
        send_meas(32'hFFFF_FFFF, 32'h0000_0001);
        drain();

        write_reg(CFG_UNUSED, {$urandom, $urandom});
        set_regs(0, NOISE_MAX, NOISE_MAX);
        send_meas(32'h8000_0000, 32'h7FFF_FFFF);
        send_meas(32'h0001_0000, 32'hFFFF_0000);
        send_meas(32'h5555_5555, 32'hAAAA_AAAA);
        drain();

        set_regs(ONE, ONE, 0);
        send_meas(32'h0010_0000, 32'h0020_0000);
        send_meas(32'h0011_0000, 32'h0022_0000);
        send_meas(32'hAAAA_AAAA, 32'h5555_5555);
        drain();

        set_regs(ONE, ONE, longint'(1000) << 24);
        for (int i = 0; i < 6; i++)
            send_meas(32'(i * 32'h0001_8000), 32'(-i * 32'h0000_4000));
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            pick = $urandom_range(0, 9);
            dt = (pick == 0) ? 0 : (pick == 1) ? DT_MAX
                                 : longint'($urandom_range(32'h0001_0000, 32'h0400_0000));
            pick = $urandom_range(0, 9);
            q = (pick == 0) ? 0 : (pick == 1) ? NOISE_MAX
                                : longint'($urandom_range(0, 32'h0400_0000));
            pick = $urandom_range(0, 9);
            r = (pick == 0) ? 0 : (pick == 1) ? NOISE_MAX
                                : longint'($urandom_range(32'h0010_0000, 32'hFFFF_FFFF));
            set_regs(dt, q, r);
            px = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
            py = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
            vx = $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
            vy = $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
            ax = 0;
            ay = 0;
            // The output is held off long enough for the block to fill and stall its input.
            if (ph == 1)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    ax = $urandom_range(0, 32'h0000_3FFF) - 32'h0000_2000;
                    ay = $urandom_range(0, 32'h0000_3FFF) - 32'h0000_2000;
                end
                vx += ax;
                vy += ay;
                px += vx;
                py += vy;
                if (pick < 78)
                    send_meas(px + $urandom_range(0, 4095) - 2048,
                              py + $urandom_range(0, 4095) - 2048);
                else
                    send_meas($urandom, $urandom);
                sender_gap();
            end
            drain();
        end

        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("kalman_filter_const_accel_2d_top verification clean");
        else
            $display("kalman_filter_const_accel_2d_top verification failed");
        $finish;
    end

endmodule
